// ===== src/dhcp_tlv_pkg.sv =====
// shared types and constants for the dhcp option tlv extractor
`default_nettype none
package dhcp_tlv_pkg;

  localparam int MAX_OPTION_BYTES = 312;
  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_OPTION_BYTES);
  localparam logic [POS_W-1:0] POS_CODE_LIMIT = POS_W'(MAX_OPTION_BYTES - 1);
  localparam logic [POS_W-1:0] POS_SAT = '1;
  localparam logic [POS_W-1:0] POS_COOKIE_LAST = POS_W'(3);

  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_SERVER = 8'd246;
  localparam logic [7:0] OPT_GATEWAY = 8'd247;
  localparam logic [7:0] OPT_NAMESPACE = 8'd248;
  localparam logic [7:0] OPT_END = 8'd255;

  localparam logic [7:0] GW_TYPE_ADDR = 8'd0;
  localparam logic [7:0] GW_TYPE_SKIP = 8'd1;
  localparam logic [7:0] GW_MIN_LEN = 8'd7;

  localparam logic [1:0] KIND_NAMESPACE = 2'd0;
  localparam logic [1:0] KIND_DOMAIN = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam int FOUND_SERVER = 0;
  localparam int FOUND_GATEWAY = 1;
  localparam int FOUND_NAMESPACE = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    PH_COOKIE,
    PH_CODE,
    PH_LEN,
    PH_VALUE
  } phase_t;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  str_byte;
    logic        str_first;
    logic        status;
    logic [31:0] server_addr;
    logic [31:0] gateway_addr;
    logic [15:0] gateway_port;
    logic        last_result;
  } out_word_t;

  // one parsed byte's worth of results: an optional string byte and an optional summary
  typedef struct packed {
    logic        has_str;
    logic [1:0]  str_kind;
    logic [7:0]  str_byte;
    logic        str_first;
    logic        has_sum;
    logic        status;
    logic [31:0] server_addr;
    logic [31:0] gateway_addr;
    logic [15:0] gateway_port;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } queue_head_t;

endpackage
`default_nettype wire

// ===== src/dhcp_tlv_front.sv =====
// option parser: takes one options byte per word and builds result events
`default_nettype none
module dhcp_tlv_front
  import dhcp_tlv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire in_word_t in_word,
  input  wire logic     q_full,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  output logic          ev_push,
  output event_t        ev
);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [7:0]       opt_code, opt_code_next;
  logic [7:0]       val_len, val_len_next;
  logic [7:0]       val_idx, val_idx_next;
  logic [7:0]       gw_type, gw_type_next;
  logic [31:0]      server_addr, server_addr_next;
  logic [31:0]      gateway_addr, gateway_addr_next;
  logic [15:0]      gateway_port, gateway_port_next;
  logic [2:0]       found, found_next;
  logic             stopped, stopped_next;
  logic             lookup_target;
  logic             accept;
  logic [7:0]       b;
  logic             ok;

  assign accept = in_valid && !q_full;
  assign b = in_word.opt_byte;
  assign ev_push = accept && (ev.has_str || ev.has_sum);

  always_comb begin
    phase_next = phase;
    opt_code_next = opt_code;
    val_len_next = val_len;
    val_idx_next = val_idx;
    gw_type_next = gw_type;
    server_addr_next = server_addr;
    gateway_addr_next = gateway_addr;
    gateway_port_next = gateway_port;
    found_next = found;
    stopped_next = stopped;
    ev = '0;
    ok = 1'b0;

    if (!stopped && byte_pos < POS_LIMIT) begin
      case (phase)
        PH_COOKIE: begin
          if (byte_pos >= POS_COOKIE_LAST) phase_next = PH_CODE;
        end
        PH_CODE: begin
          if (byte_pos < POS_CODE_LIMIT && b != OPT_PAD) begin
            if (b == OPT_END) begin
              stopped_next = 1'b1;
            end else begin
              opt_code_next = b;
              phase_next = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          val_len_next = b;
          val_idx_next = 8'd0;
          if (opt_code == OPT_SERVER) begin
            found_next[FOUND_SERVER] = 1'b1;
            server_addr_next = 32'd0;
          end else if (opt_code == OPT_NAMESPACE) begin
            found_next[FOUND_NAMESPACE] = 1'b1;
          end
          phase_next = (b == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          if (opt_code == OPT_SERVER) begin
            case (val_idx)
              8'd0: server_addr_next[31:24] = server_addr[31:24] | b;
              8'd1: server_addr_next[23:16] = server_addr[23:16] | b;
              8'd2: server_addr_next[15:8] = server_addr[15:8] | b;
              8'd3: server_addr_next[7:0] = server_addr[7:0] | b;
              default: ;
            endcase
          end else if (opt_code == OPT_NAMESPACE) begin
            ev.has_str = 1'b1;
            ev.str_kind = KIND_NAMESPACE;
            ev.str_byte = b;
            ev.str_first = (val_idx == 8'd0);
          end else if (opt_code == OPT_GATEWAY && val_len >= GW_MIN_LEN) begin
            if (val_idx == 8'd0) begin
              gw_type_next = b;
              if (b == GW_TYPE_ADDR) begin
                found_next[FOUND_GATEWAY] = 1'b1;
              end else if (b != GW_TYPE_SKIP) begin
                stopped_next = 1'b1;
              end
            end else if (gw_type == GW_TYPE_ADDR) begin
              case (val_idx)
                8'd1: gateway_addr_next[31:24] = b;
                8'd2: gateway_addr_next[23:16] = b;
                8'd3: gateway_addr_next[15:8] = b;
                8'd4: gateway_addr_next[7:0] = b;
                8'd5: gateway_port_next[15:8] = b;
                8'd6: gateway_port_next[7:0] = b;
                default: begin
                  ev.has_str = 1'b1;
                  ev.str_kind = KIND_DOMAIN;
                  ev.str_byte = b;
                  ev.str_first = (val_idx == 8'd7);
                end
              endcase
            end
          end
          val_idx_next = val_idx + 8'd1;
          if ({1'b0, val_idx} + 9'd1 >= {1'b0, val_len}) phase_next = PH_CODE;
        end
        default: phase_next = PH_COOKIE;
      endcase
    end

    byte_pos_next = (byte_pos != POS_SAT) ? byte_pos + POS_W'(1) : byte_pos;

    if (in_word.end_of_packet) begin
      if (lookup_target) begin
        ok = found_next[FOUND_GATEWAY] && found_next[FOUND_NAMESPACE];
      end else begin
        ok = found_next[FOUND_SERVER];
      end
      ev.has_sum = 1'b1;
      ev.status = !ok;
      ev.server_addr = server_addr_next;
      ev.gateway_addr = gateway_addr_next;
      ev.gateway_port = gateway_port_next;
      // packet done: back to the cookie
      phase_next = PH_COOKIE;
      byte_pos_next = '0;
      opt_code_next = 8'd0;
      val_len_next = 8'd0;
      val_idx_next = 8'd0;
      gw_type_next = 8'd0;
      server_addr_next = 32'd0;
      gateway_addr_next = 32'd0;
      gateway_port_next = 16'd0;
      found_next = 3'd0;
      stopped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COOKIE;
      byte_pos <= '0;
      opt_code <= 8'd0;
      val_len <= 8'd0;
      val_idx <= 8'd0;
      gw_type <= 8'd0;
      server_addr <= 32'd0;
      gateway_addr <= 32'd0;
      gateway_port <= 16'd0;
      found <= 3'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      byte_pos <= byte_pos_next;
      opt_code <= opt_code_next;
      val_len <= val_len_next;
      val_idx <= val_idx_next;
      gw_type <= gw_type_next;
      server_addr <= server_addr_next;
      gateway_addr <= gateway_addr_next;
      gateway_port <= gateway_port_next;
      found <= found_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lookup_target <= 1'b0;
    end else if (cfg_we) begin
      lookup_target <= cfg_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/dhcp_tlv_queue.sv =====
// short event queue between the parser and the output stage
`default_nettype none
module dhcp_tlv_queue
  import dhcp_tlv_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire event_t push_ev,
  input  wire logic   pop,
  output logic        full,
  output queue_head_t head
);

  event_t            entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.ev = entries[rd_ptr];
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, do_pop})
        2'b10: count <= count + QCNT_W'(1);
        2'b01: count <= count - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/dhcp_tlv_back.sv =====
// output stage: turns queued events into result words
`default_nettype none
module dhcp_tlv_back
  import dhcp_tlv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word
);

  logic      out_valid_next;
  out_word_t out_word_next;
  logic      str_done, str_done_next;
  logic      load;

  always_comb begin
    load = !out_valid || !out_stall;
    pop = 1'b0;
    out_valid_next = out_valid && out_stall;
    out_word_next = out_word;
    str_done_next = str_done;
    if (load && head.valid) begin
      out_valid_next = 1'b1;
      out_word_next = '0;
      if (head.ev.has_str && !str_done) begin
        out_word_next.kind = head.ev.str_kind;
        out_word_next.str_byte = head.ev.str_byte;
        out_word_next.str_first = head.ev.str_first;
        out_word_next.last_result = !head.ev.has_sum;
        // summary still to follow from the same event
        if (head.ev.has_sum) begin
          str_done_next = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_word_next.kind = KIND_SUMMARY;
        out_word_next.status = head.ev.status;
        out_word_next.server_addr = head.ev.server_addr;
        out_word_next.gateway_addr = head.ev.gateway_addr;
        out_word_next.gateway_port = head.ev.gateway_port;
        out_word_next.last_result = 1'b1;
        pop = 1'b1;
        str_done_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      str_done <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      str_done <= str_done_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
  end

endmodule
`default_nettype wire

// ===== src/dhcp_option_tlv_extractor_top.sv =====
// top level of the dhcp option tlv extractor
`default_nettype none
// Takes a DHCP options area one byte per word (cookie first, end_of_packet on
// the last byte) and returns namespace bytes (option 248), domain bytes
// (option 247, address type 0, after the address and port) and one summary
// word per packet carrying the captured server address, gateway address and
// port and a found status chosen by the lookup_target register. The block
// takes one input word per cycle unless in_stall is high; the parser feeds
// a four-entry event queue ahead of a registered output stage, so output
// stalls are absorbed until the queue fills. A byte that ends a packet
// while also giving a string byte yields two result words, which the output
// stage sends one after the other. Write lookup_target only while idle.
module dhcp_option_tlv_extractor_top
  import dhcp_tlv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  logic        q_full;
  logic        ev_push;
  event_t      ev;
  logic        pop;
  queue_head_t head;

  assign in_stall = q_full;
  assign cfg_ready = 1'b1;

  dhcp_tlv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .ev_push  (ev_push),
    .ev       (ev)
  );

  dhcp_tlv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_push),
    .push_ev (ev),
    .pop     (pop),
    .full    (q_full),
    .head    (head)
  );

  dhcp_tlv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// ===== tb/dhcp_option_tlv_extractor_checker.sv =====
// option byte parser model and result word comparison for the tlv extractor
`timescale 1ns / 100ps
module dhcp_option_tlv_extractor_checker
  import dhcp_tlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        fail_count,
  output int        pending_words
);

  out_word_t expected_words[$];
  int errors = 0;

  logic               target;
  phase_t             phase;
  logic [POS_W-1:0]   pos;
  logic [7:0]         code;
  logic [7:0]         vlen;
  logic [7:0]         vidx;
  logic [7:0]         gw_type;
  logic [31:0]        srv_addr;
  logic [31:0]        gw_addr;
  logic [15:0]        gw_port;
  logic [2:0]         found;
  logic               halted;

  initial begin
    fail_count = 0;
    pending_words = 0;
  end

  function void clear_packet();
    phase = PH_COOKIE;
    pos = '0;
    code = '0;
    vlen = '0;
    vidx = '0;
    gw_type = '0;
    srv_addr = '0;
    gw_addr = '0;
    gw_port = '0;
    found = '0;
    halted = 1'b0;
  endfunction

  function automatic out_word_t string_word(logic [1:0] k, logic [7:0] b, logic first);
    out_word_t sw;
    sw = '0;
    sw.kind = k;
    sw.str_byte = b;
    sw.str_first = first;
    return sw;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  // one option byte in, zero to two result words out
  task automatic parse_word(input in_word_t w);
    out_word_t  produced[$];
    out_word_t  summary;
    logic [7:0] b;
    int         idx;
    logic       ok;
    b = w.opt_byte;
    if (!halted && pos < POS_LIMIT) begin
      case (phase)
        PH_COOKIE: begin
          if (pos >= POS_COOKIE_LAST) phase = PH_CODE;
        end
        PH_CODE: begin
          // code byte in the last slot before the limit is dropped
          if (pos >= POS_CODE_LIMIT || b == OPT_PAD) begin
          end else if (b == OPT_END) begin
            halted = 1'b1;
          end else begin
            code = b;
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          vlen = b;
          vidx = '0;
          if (code == OPT_SERVER) begin
            found[FOUND_SERVER] = 1'b1;
            srv_addr = '0;
          end else if (code == OPT_NAMESPACE) begin
            found[FOUND_NAMESPACE] = 1'b1;
          end
          phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
        end
        default: begin
          idx = int'(vidx);
          if (code == OPT_SERVER) begin
            if (idx < 4) srv_addr[8*(3-idx) +: 8] |= b;
          end else if (code == OPT_NAMESPACE) begin
            produced.push_back(string_word(KIND_NAMESPACE, b, idx == 0));
          end else if (code == OPT_GATEWAY && vlen >= GW_MIN_LEN) begin
            if (idx == 0) begin
              gw_type = b;
              if (b == GW_TYPE_ADDR) found[FOUND_GATEWAY] = 1'b1;
              else if (b != GW_TYPE_SKIP) halted = 1'b1;
            end else if (gw_type == GW_TYPE_ADDR) begin
              if (idx <= 4) gw_addr[8*(4-idx) +: 8] = b;
              else if (idx == 5) gw_port[15:8] = b;
              else if (idx == 6) gw_port[7:0] = b;
              else produced.push_back(string_word(KIND_DOMAIN, b, idx == 7));
            end
          end
          vidx = vidx + 8'd1;
          if (idx + 1 >= int'(vlen)) phase = PH_CODE;
        end
      endcase
    end
    if (pos != POS_SAT) pos = pos + POS_W'(1);

    if (w.end_of_packet) begin
      ok = target ? (found[FOUND_GATEWAY] && found[FOUND_NAMESPACE]) : found[FOUND_SERVER];
      summary = '0;
      summary.kind = KIND_SUMMARY;
      summary.status = !ok;
      summary.server_addr = srv_addr;
      summary.gateway_addr = gw_addr;
      summary.gateway_port = gw_port;
      produced.push_back(summary);
      clear_packet();
    end
    if (produced.size() > 0) produced[produced.size()-1].last_result = 1'b1;
    foreach (produced[i]) expected_words.push_back(produced[i]);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      target = 1'b0;
      clear_packet();
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) target = cfg_data;
      if (in_valid && !in_stall) parse_word(in_word);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d byte 0x%0h", out_word.kind,
                 out_word.str_byte);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_word.kind));
          check_field("str_byte", 32'(want.str_byte), 32'(out_word.str_byte));
          check_field("str_first", 32'(want.str_first), 32'(out_word.str_first));
          check_field("status", 32'(want.status), 32'(out_word.status));
          check_field("server_addr", want.server_addr, out_word.server_addr);
          check_field("gateway_addr", want.gateway_addr, out_word.gateway_addr);
          check_field("gateway_port", 32'(want.gateway_port), 32'(out_word.gateway_port));
          check_field("last_result", 32'(want.last_result), 32'(out_word.last_result));
        end
      end
    end
    fail_count <= errors;
    pending_words <= expected_words.size();
  end

endmodule

// ===== tb/dhcp_option_tlv_extractor_top_tb.sv =====
// testbench top for the tlv extractor: packet stimulus, stall patterns and verdict
`timescale 1ns / 100ps
module dhcp_option_tlv_extractor_top_tb;
  import dhcp_tlv_pkg::*;

  localparam int PHASE_ITEMS      = 290;
  localparam int NUM_PHASES       = 6;
  localparam int DRAIN_CYCLES     = 12;
  localparam int IDLE_LIMIT       = 4000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int HOLD_INTERVAL    = 1500;

  typedef enum int {
    PICK_PAD,
    PICK_SERVER,
    PICK_NAMESPACE,
    PICK_GATEWAY,
    PICK_GATEWAY_SKIP,
    PICK_GATEWAY_BAD,
    PICK_GATEWAY_SHORT,
    PICK_OTHER,
    PICK_END
  } option_pick_e;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data = 1'b0;
  logic      in_stall;
  logic      out_valid;
  logic      cfg_ready;
  out_word_t out_word;
  int        fail_count;
  int        pending_words;

  logic [7:0] pkt_bytes[$];
  int burst_left = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  dhcp_option_tlv_extractor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dhcp_option_tlv_extractor_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("dhcp_option_tlv_extractor_top: mismatch");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off now and then to back up the input
  initial begin
    stall_mode_e mode;
    int seg_len;
    int since_hold;
    since_hold = HOLD_INTERVAL - 600;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (since_hold >= HOLD_INTERVAL) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        since_hold = 0;
      end
      mode = stall_mode_e'($urandom_range(0, 3));
      seg_len = $urandom_range(8, 120);
      repeat (seg_len) begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
        since_hold++;
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eop);
    int gap;
    in_word <= '{opt_byte: b, end_of_packet: eop};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  task automatic write_target(input logic value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // drain every expected word, then give the parser time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(input int count);
    repeat (count) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic option_pick_e random_pick();
    int r;
    r = $urandom_range(0, 11);
    // extra weight on gateway and namespace so the target 1 lookup succeeds often
    if (r > PICK_END) return (r % 2) ? PICK_GATEWAY : PICK_NAMESPACE;
    return option_pick_e'(r);
  endfunction

  task automatic add_option(input option_pick_e pick);
    int len;
    case (pick)
      PICK_PAD: pkt_bytes.push_back(OPT_PAD);
      PICK_SERVER: begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : 4;
        pkt_bytes.push_back(OPT_SERVER);
        pkt_bytes.push_back(8'(len));
        push_random(len);
      end
      PICK_NAMESPACE: begin
        len = $urandom_range(0, 12);
        pkt_bytes.push_back(OPT_NAMESPACE);
        pkt_bytes.push_back(8'(len));
        push_random(len);
      end
      PICK_GATEWAY: begin
        len = $urandom_range(7, 16);
        pkt_bytes.push_back(OPT_GATEWAY);
        pkt_bytes.push_back(8'(len));
        pkt_bytes.push_back(GW_TYPE_ADDR);
        push_random(len - 1);
      end
      PICK_GATEWAY_SKIP: begin
        len = $urandom_range(7, 10);
        pkt_bytes.push_back(OPT_GATEWAY);
        pkt_bytes.push_back(8'(len));
        pkt_bytes.push_back(GW_TYPE_SKIP);
        push_random(len - 1);
      end
      PICK_GATEWAY_BAD: begin
        len = $urandom_range(7, 10);
        pkt_bytes.push_back(OPT_GATEWAY);
        pkt_bytes.push_back(8'(len));
        pkt_bytes.push_back(8'($urandom_range(2, 255)));
        push_random(len - 1);
      end
      PICK_GATEWAY_SHORT: begin
        len = $urandom_range(0, 6);
        pkt_bytes.push_back(OPT_GATEWAY);
        pkt_bytes.push_back(8'(len));
        push_random(len);
      end
      PICK_OTHER: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(249, 254))
                                                         : 8'($urandom_range(1, 245)));
        pkt_bytes.push_back(8'(len));
        push_random(len);
      end
      default: pkt_bytes.push_back(OPT_END);
    endcase
  endtask

  task automatic build_packet();
    int r;
    int keep;
    int stop_at;
    option_pick_e pick;
    pkt_bytes.delete();
    r = $urandom_range(0, 29);
    if (r == 0) begin
      push_random($urandom_range(1, 40));
    end else if (r == 1) begin
      // packet ends inside the cookie
      push_random($urandom_range(1, 4));
    end else begin
      push_random(4);
      if (r == 2) begin
        // run past the options limit, parsing kept alive
        stop_at = $urandom_range(300, 530);
        while (pkt_bytes.size() < stop_at) begin
          pick = random_pick();
          if (pick == PICK_END || pick == PICK_GATEWAY_BAD) pick = PICK_OTHER;
          add_option(pick);
        end
      end else begin
        repeat ($urandom_range(1, 6)) add_option(random_pick());
      end
      if ($urandom_range(0, 5) == 0) begin
        keep = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
      end
      if ($urandom_range(0, 5) == 0) push_random($urandom_range(1, 3));
    end
  endtask

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // server lookup: pad, short server option, empty namespace, end code, ignored tail
    write_target(1'b0);
    pkt_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, OPT_PAD, OPT_SERVER, 8'd2, 8'hff, 8'h80,
                  OPT_NAMESPACE, 8'd0, OPT_END, 8'h07};
    send_packet();
    wait_idle();

    // gateway lookup: namespace byte, full gateway option, domain byte on the last word
    write_target(1'b1);
    pkt_bytes = '{8'h63, 8'h82, 8'h53, 8'h63, OPT_NAMESPACE, 8'd1, 8'h6e, OPT_GATEWAY, 8'd8,
                  GW_TYPE_ADDR, 8'hc0, 8'ha8, 8'h01, 8'hfe, 8'h1f, 8'h90, 8'h61};
    send_packet();
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_target(1'(ph % 2));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_packet();
        send_packet();
        sent += pkt_bytes.size();
      end
      wait_idle();
    end

    @(negedge clk);
    if (fail_count == 0 && pending_words == 0)
      $display("dhcp_option_tlv_extractor_top: match");
    else
      $display("dhcp_option_tlv_extractor_top: mismatch");
    $finish;
  end

endmodule
